// ===== hdl/plnk_pkg.sv =====
// Shared types, field widths and codes for the PLL N/K factor search block.
`timescale 1ns / 1ps

package plnk_pkg;

   // Fixed field widths
   localparam int RATE_W     = 32;
   localparam int FUNC_W     = 2;
   localparam int NF_OUT_W   = 6;
   localparam int KF_OUT_W   = 3;
   localparam int NRANGE_W   = 6;
   localparam int KRANGE_W   = 3;
   localparam int PD_W       = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Default code field widths
   localparam int N_WIDTH_DEF = 5;
   localparam int K_WIDTH_DEF = 2;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_ROUND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RECALC = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_N_MIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_N_MAX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_MIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_MAX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_N_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_K_OFFSET = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PD_EN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PD_VALUE = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [RATE_W-1:0] parent_rate;
      logic [RATE_W-1:0] target_rate;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   rate;
      logic [NF_OUT_W-1:0] n_factor;
      logic [KF_OUT_W-1:0] k_factor;
   } rsp_type;

endpackage

// ===== hdl/pll_nk_factor_search.sv =====
// Top level of the PLL N/K factor search: sequencer, search datapath and bit-serial divider.
`timescale 1ns / 1ps

// From accept to result beat a request passes the prep steps (PREP_K, PREP_N), the search, the
// serial divide with the post divider on, and the finish step; an unknown func goes straight to
// the finish step. The search tests one pair per cycle, (n_hi - n_lo + 1) * (k_hi - k_lo + 1)
// pairs for round/set (none for recalc or an empty range); the divide yields P_W (41) serial
// quotient bits. Busy from accept to result beat, taking no new request; no receiver stall.
// Synchronous active-high reset restores register defaults, clears the N/K codes and idles.
module pll_nk_factor_search #(
   parameter int N_WIDTH = plnk_pkg::N_WIDTH_DEF,
   parameter int K_WIDTH = plnk_pkg::K_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  plnk_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   output plnk_pkg::rsp_type                   rsp_data,
   // register write port
   input  logic                                csr_we,
   input  logic [plnk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [plnk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // internal factor widths: wide enough for the register ranges and for 2^WIDTH
   localparam int NF_W  = (N_WIDTH + 1 > plnk_pkg::NRANGE_W) ? N_WIDTH + 1 : plnk_pkg::NRANGE_W;
   localparam int KF_W  = (K_WIDTH + 1 > plnk_pkg::KRANGE_W) ? K_WIDTH + 1 : plnk_pkg::KRANGE_W;
   localparam int PK_W  = plnk_pkg::RATE_W + KF_W;           // parent * k
   localparam int P_W   = PK_W + NF_W;                       // parent * n * k
   localparam int TGT_W = plnk_pkg::RATE_W + plnk_pkg::PD_W; // target * postdiv
   localparam int DC_W  = $clog2(P_W);
   localparam int PD_W  = plnk_pkg::PD_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP_K = 6'b000010,
      ST_PREP_N = 6'b000100,
      ST_SEARCH = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [plnk_pkg::NRANGE_W-1:0] n_min_ff, n_min_in, n_max_ff, n_max_in;
   logic [plnk_pkg::KRANGE_W-1:0] k_min_ff, k_min_in, k_max_ff, k_max_in;
   logic                          n_offset_ff, n_offset_in, k_offset_ff, k_offset_in;
   logic                          pd_en_ff, pd_en_in;
   logic [PD_W-1:0]               pd_value_ff, pd_value_in;

   // stored codes
   logic [N_WIDTH-1:0] n_code_ff, n_code_in;
   logic [K_WIDTH-1:0] k_code_ff, k_code_in;

   // datapath (no reset)
   logic [plnk_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [plnk_pkg::RATE_W-1:0] parent_ff, parent_in;
   logic [TGT_W-1:0]            tgt_ff, tgt_in;
   logic [PK_W-1:0]             pk_ff, pk_in;
   logic [P_W-1:0]              pn_ff, pn_in;
   logic [P_W-1:0]              base_ff, base_in;
   logic [P_W-1:0]              p_ff, p_in;
   logic [P_W-1:0]              best_ff, best_in;
   logic [P_W-1:0]              val_ff, val_in;
   logic [NF_W-1:0]             n_ff, n_in, nf_ff, nf_in;
   logic [KF_W-1:0]             k_ff, k_in, kf_ff, kf_in;
   logic [PD_W-1:0]             rem_ff, rem_in;
   logic [DC_W-1:0]             dcnt_ff, dcnt_in;
   plnk_pkg::rsp_type           rsp_ff, rsp_in;

   // ---------------------------------------------------------------- combinational helpers
   logic [PD_W-1:0]    pd_eff;
   logic [NF_W-1:0]    n_lo, n_hi;
   logic [KF_W-1:0]    k_lo, k_hi;
   logic               is_recalc;
   logic [N_WIDTH:0]   n_sum;
   logic [K_WIDTH:0]   k_sum;
   logic [NF_W-1:0]    nf_rc;
   logic [KF_W-1:0]    kf_rc;
   logic [P_W-1:0]     mulb;
   logic               hit;
   logic [P_W-1:0]     best_upd;
   logic [NF_W-1:0]    nf_upd;
   logic [KF_W-1:0]    kf_upd;
   logic [PD_W:0]      rem_shift, rem_sub;
   logic               q_bit;
   logic               store_en;
   logic [NF_W-1:0]    store_nf;
   logic [KF_W-1:0]    store_kf;
   logic [NF_W-1:0]    nf_code_full;
   logic [KF_W-1:0]    kf_code_full;
   state_type          post_state;

   always_comb begin
      pd_eff    = (pd_value_ff == '0) ? PD_W'(1) : pd_value_ff;
      n_lo      = NF_W'(n_min_ff);
      k_lo      = KF_W'(k_min_ff);
      n_hi      = (n_max_ff == '0) ? NF_W'(1 << N_WIDTH) : NF_W'(n_max_ff);
      k_hi      = (k_max_ff == '0) ? KF_W'(1 << K_WIDTH) : KF_W'(k_max_ff);
      is_recalc = (func_ff == plnk_pkg::FUNC_RECALC);

      // recalc factors: a factor of zero counts as one
      n_sum = (N_WIDTH+1)'(n_code_ff) + (N_WIDTH+1)'(n_offset_ff);
      k_sum = (K_WIDTH+1)'(k_code_ff) + (K_WIDTH+1)'(k_offset_ff);
      nf_rc = (n_sum == '0) ? NF_W'(1) : NF_W'(n_sum);
      kf_rc = (k_sum == '0) ? KF_W'(1) : KF_W'(k_sum);

      // second product of the prep pair: (parent * k) * n
      mulb = P_W'(pk_ff) * P_W'(is_recalc ? nf_ff : n_lo);

      // candidate compare: fits under target and strictly better (first found wins ties)
      hit      = (p_ff <= P_W'(tgt_ff)) && (p_ff > best_ff);
      best_upd = hit ? p_ff : best_ff;
      nf_upd   = hit ? n_ff : nf_ff;
      kf_upd   = hit ? k_ff : kf_ff;

      // restoring divider step
      rem_shift = {rem_ff, val_ff[P_W-1]};
      rem_sub   = rem_shift - {1'b0, pd_eff};
      q_bit     = (rem_shift >= {1'b0, pd_eff});

      post_state = pd_en_ff ? ST_DIVIDE : ST_FINISH;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      func_in      = func_ff;
      parent_in    = parent_ff;
      tgt_in       = tgt_ff;
      pk_in        = pk_ff;
      pn_in        = pn_ff;
      base_in      = base_ff;
      p_in         = p_ff;
      best_in      = best_ff;
      val_in       = val_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      nf_in        = nf_ff;
      kf_in        = kf_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      rsp_in       = rsp_ff;
      store_en     = 1'b0;
      store_nf     = nf_upd;
      store_kf     = kf_upd;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in   = req_data.func;
               parent_in = req_data.parent_rate;
               // scale target up by the post divider so the search compares pre-divider rates
               tgt_in    = pd_en_ff ? TGT_W'(req_data.target_rate) * TGT_W'(pd_eff)
                                    : TGT_W'(req_data.target_rate);
               case (req_data.func)
                  plnk_pkg::FUNC_ROUND,
                  plnk_pkg::FUNC_SET: begin
                     state_in = ST_PREP_K;
                  end
                  plnk_pkg::FUNC_RECALC: begin
                     nf_in    = nf_rc;
                     kf_in    = kf_rc;
                     state_in = ST_PREP_K;
                  end
                  default: begin
                     // unknown function: zero answer, codes untouched
                     val_in   = '0;
                     nf_in    = '0;
                     kf_in    = '0;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_PREP_K: begin
            pk_in    = PK_W'(parent_ff) * PK_W'(is_recalc ? kf_ff : k_lo);
            state_in = ST_PREP_N;
         end

         ST_PREP_N: begin
            if (is_recalc) begin
               val_in   = mulb;
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = post_state;
            end else begin
               pn_in   = P_W'(parent_ff) * P_W'(n_lo);
               base_in = mulb;
               p_in    = mulb;
               best_in = '0;
               nf_in   = '0;
               kf_in   = '0;
               n_in    = n_lo;
               k_in    = k_lo;
               if ((n_lo > n_hi) || (k_lo > k_hi)) begin
                  // empty range: nothing fits
                  val_in   = '0;
                  store_en = (func_ff == plnk_pkg::FUNC_SET);
                  store_nf = '0;
                  store_kf = '0;
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = post_state;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            best_in = best_upd;
            nf_in   = nf_upd;
            kf_in   = kf_upd;
            if (k_ff == k_hi) begin
               if (n_ff == n_hi) begin
                  val_in   = best_upd;
                  store_en = (func_ff == plnk_pkg::FUNC_SET);
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = post_state;
               end else begin
                  // next N row: products step by parent and parent * k_lo
                  n_in    = n_ff + NF_W'(1);
                  k_in    = k_lo;
                  pn_in   = pn_ff + P_W'(parent_ff);
                  base_in = base_ff + P_W'(pk_ff);
                  p_in    = base_ff + P_W'(pk_ff);
               end
            end else begin
               k_in = k_ff + KF_W'(1);
               p_in = p_ff + pn_ff;
            end
         end

         ST_DIVIDE: begin
            val_in  = {val_ff[P_W-2:0], q_bit};
            rem_in  = q_bit ? rem_sub[PD_W-1:0] : rem_shift[PD_W-1:0];
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(P_W - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_in.rate     = (|val_ff[P_W-1:plnk_pkg::RATE_W]) ? '1
                                                                : val_ff[plnk_pkg::RATE_W-1:0];
            rsp_in.n_factor = nf_ff[plnk_pkg::NF_OUT_W-1:0];
            rsp_in.k_factor = kf_ff[plnk_pkg::KF_OUT_W-1:0];
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // stored codes: factor minus offset, wrapped to the code width
   always_comb begin
      nf_code_full = store_nf - NF_W'(n_offset_ff);
      kf_code_full = store_kf - KF_W'(k_offset_ff);
      n_code_in    = store_en ? nf_code_full[N_WIDTH-1:0] : n_code_ff;
      k_code_in    = store_en ? kf_code_full[K_WIDTH-1:0] : k_code_ff;
   end

   // register writes
   always_comb begin
      n_min_in    = n_min_ff;
      n_max_in    = n_max_ff;
      k_min_in    = k_min_ff;
      k_max_in    = k_max_ff;
      n_offset_in = n_offset_ff;
      k_offset_in = k_offset_ff;
      pd_en_in    = pd_en_ff;
      pd_value_in = pd_value_ff;
      if (csr_we) begin
         case (csr_index)
            plnk_pkg::CSR_N_MIN:    n_min_in    = csr_wdata[plnk_pkg::NRANGE_W-1:0];
            plnk_pkg::CSR_N_MAX:    n_max_in    = csr_wdata[plnk_pkg::NRANGE_W-1:0];
            plnk_pkg::CSR_K_MIN:    k_min_in    = csr_wdata[plnk_pkg::KRANGE_W-1:0];
            plnk_pkg::CSR_K_MAX:    k_max_in    = csr_wdata[plnk_pkg::KRANGE_W-1:0];
            plnk_pkg::CSR_N_OFFSET: n_offset_in = csr_wdata[0];
            plnk_pkg::CSR_K_OFFSET: k_offset_in = csr_wdata[0];
            plnk_pkg::CSR_PD_EN:    pd_en_in    = csr_wdata[0];
            plnk_pkg::CSR_PD_VALUE: pd_value_in = csr_wdata[PD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_min_ff     <= plnk_pkg::NRANGE_W'(1);
         n_max_ff     <= '0;
         k_min_ff     <= plnk_pkg::KRANGE_W'(1);
         k_max_ff     <= '0;
         n_offset_ff  <= 1'b1;
         k_offset_ff  <= 1'b1;
         pd_en_ff     <= 1'b0;
         pd_value_ff  <= PD_W'(1);
         n_code_ff    <= '0;
         k_code_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_min_ff     <= n_min_in;
         n_max_ff     <= n_max_in;
         k_min_ff     <= k_min_in;
         k_max_ff     <= k_max_in;
         n_offset_ff  <= n_offset_in;
         k_offset_ff  <= k_offset_in;
         pd_en_ff     <= pd_en_in;
         pd_value_ff  <= pd_value_in;
         n_code_ff    <= n_code_in;
         k_code_ff    <= k_code_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      parent_ff <= parent_in;
      tgt_ff    <= tgt_in;
      pk_ff     <= pk_in;
      pn_ff     <= pn_in;
      base_ff   <= base_in;
      p_ff      <= p_in;
      best_ff   <= best_in;
      val_ff    <= val_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      nf_ff     <= nf_in;
      kf_ff     <= kf_in;
      rem_ff    <= rem_in;
      dcnt_ff   <= dcnt_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // a result beat only follows the finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FINISH))
      else $error("result beat without finish step");

   // an accepted request always occupies the block next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // the best product never exceeds the scaled target
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (best_ff <= P_W'(tgt_ff)))
      else $error("best product above target");

   // search counters stay inside the configured ranges
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (n_ff >= n_lo && n_ff <= n_hi && k_ff >= k_lo && k_ff <= k_hi))
      else $error("search counter out of range");
`endif

endmodule

// ===== tb/pll_nk_factor_search_tb.sv =====
// Self-checking testbench for the PLL N/K factor search block.
`timescale 1ns / 1ps

module pll_nk_factor_search_tb;

   localparam int NW = plnk_pkg::N_WIDTH_DEF;
   localparam int KW = plnk_pkg::K_WIDTH_DEF;
   // func 3 is not a defined operation; the block must answer all zeros
   localparam logic [plnk_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;
   // worst search is 64 x 8 pairs plus the serial divide and some margin
   localparam int TAIL_WAIT = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   plnk_pkg::req_type req_data = '0;
   logic rsp_valid;
   plnk_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [plnk_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [plnk_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pll_nk_factor_search dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the registers and the stored codes, reset values
   // ---------------------------------------------------------------------
   logic [5:0]    n_min_r  = 6'd1;
   logic [5:0]    n_max_r  = 6'd0;
   logic [2:0]    k_min_r  = 3'd1;
   logic [2:0]    k_max_r  = 3'd0;
   logic          n_off_r  = 1'b1;
   logic          k_off_r  = 1'b1;
   logic          pd_en_r  = 1'b0;
   logic [4:0]    pd_val_r = 5'd1;
   logic [NW-1:0] n_code_q = '0;
   logic [KW-1:0] k_code_q = '0;

   plnk_pkg::req_type cmd_fifo[$];     // commands waiting for the driver
   plnk_pkg::rsp_type answers[$];      // predicted result beats, oldest first

   int  n_queued   = 0;
   int  n_accepted = 0;
   int  n_checked  = 0;
   int  n_errors   = 0;
   int  n_settings = 1;
   int  cycle_cnt  = 0;
   bit  gaps_on    = 1'b1;
   bit  req_taken  = 1'b0;

   // a post divider of zero behaves as one
   function automatic int unsigned post_div();
      return (pd_val_r == 5'd0) ? 1 : int'(pd_val_r);
   endfunction

   // divide by the post divider when enabled, then clamp to 32 bits
   function automatic logic [plnk_pkg::RATE_W-1:0] scale_out(longint unsigned r);
      if (pd_en_r)
         r = r / post_div();
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   // Computes the result beat for one command and updates the stored codes.
   function automatic plnk_pkg::rsp_type nk_answer(plnk_pkg::req_type rq);
      plnk_pkg::rsp_type ans;
      longint unsigned parent, target, best, prod;
      logic [plnk_pkg::RATE_W-1:0] rate;
      int unsigned n_lo, n_hi, k_lo, k_hi, n, k, nf, kf;
      parent = rq.parent_rate;
      target = rq.target_rate;
      best = 0;
      rate = '0;
      nf = 0;
      kf = 0;
      case (rq.func)
         plnk_pkg::FUNC_ROUND, plnk_pkg::FUNC_SET: begin
            n_lo = n_min_r;
            n_hi = (n_max_r == 6'd0) ? (1 << NW) : n_max_r;
            k_lo = k_min_r;
            k_hi = (k_max_r == 3'd0) ? (1 << KW) : k_max_r;
            if (pd_en_r)
               target = target * post_div();
            // N outer, K inner, both rising; only a strictly closer pair wins,
            // so a zero product can never displace the initial best of zero
            for (n = n_lo; n <= n_hi; n++) begin
               for (k = k_lo; k <= k_hi; k++) begin
                  prod = parent * n * k;
                  if (prod <= target && (target - prod) < (target - best)) begin
                     best = prod;
                     nf = n;
                     kf = k;
                  end
               end
            end
            rate = scale_out(parent * nf * kf);
            if (rq.func == plnk_pkg::FUNC_SET) begin
               n_code_q = NW'(nf - n_off_r);
               k_code_q = KW'(kf - k_off_r);
            end
         end
         plnk_pkg::FUNC_RECALC: begin
            nf = n_code_q + n_off_r;
            kf = k_code_q + k_off_r;
            if (nf == 0) nf = 1;
            if (kf == 0) kf = 1;
            rate = scale_out(parent * nf * kf);
         end
         default: begin
            rate = '0;
         end
      endcase
      ans.rate = rate;
      ans.n_factor = nf[5:0];
      ans.k_factor = kf[2:0];
      return ans;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued commands on the falling edge, drops start at
   // random while a command waits so gaps land anywhere around busy
   // ---------------------------------------------------------------------
   plnk_pkg::req_type cur_cmd = '0;
   bit                holding = 1'b0;

   always @(negedge clock) begin
      if (req_taken)
         holding = 1'b0;
      if (!holding && cmd_fifo.size() != 0) begin
         cur_cmd = cmd_fifo.pop_front();
         holding = 1'b1;
      end
      start <= holding && !(gaps_on && $urandom_range(99) < 12);
      req_data <= cur_cmd;
   end

   // accept edge: predict the answer from the beat the block just took
   always @(posedge clock) begin
      req_taken = !reset && start && !busy;
      if (req_taken) begin
         answers.push_back(nk_answer(req_data));
         n_accepted++;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every result beat is checked against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      plnk_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (answers.size() == 0) begin
            $display("%0t unexpected result beat: rate %h n %0d k %0d",
                     $time, rsp_data.rate, rsp_data.n_factor, rsp_data.k_factor);
            n_errors++;
         end else begin
            want = answers.pop_front();
            n_checked++;
            if (rsp_data.rate !== want.rate) begin
               $display("%0t rate mismatch: expected %h actual %h",
                        $time, want.rate, rsp_data.rate);
               n_errors++;
            end
            if (rsp_data.n_factor !== want.n_factor) begin
               $display("%0t n_factor mismatch: expected %0d actual %0d",
                        $time, want.n_factor, rsp_data.n_factor);
               n_errors++;
            end
            if (rsp_data.k_factor !== want.k_factor) begin
               $display("%0t k_factor mismatch: expected %0d actual %0d",
                        $time, want.k_factor, rsp_data.k_factor);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d beats outstanding", $time, answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic send(input logic [plnk_pkg::FUNC_W-1:0] fn,
                       input logic [plnk_pkg::RATE_W-1:0] parent,
                       input logic [plnk_pkg::RATE_W-1:0] target);
      plnk_pkg::req_type rq;
      rq.func = fn;
      rq.parent_rate = parent;
      rq.target_rate = target;
      cmd_fifo.push_back(rq);
      n_queued++;
   endtask

   // register write, shadow copy masked to the register width
   task automatic write_reg(input logic [plnk_pkg::CSR_IDX_W-1:0] idx,
                            input logic [plnk_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         plnk_pkg::CSR_N_MIN:    n_min_r  = val[5:0];
         plnk_pkg::CSR_N_MAX:    n_max_r  = val[5:0];
         plnk_pkg::CSR_K_MIN:    k_min_r  = val[2:0];
         plnk_pkg::CSR_K_MAX:    k_max_r  = val[2:0];
         plnk_pkg::CSR_N_OFFSET: n_off_r  = val[0];
         plnk_pkg::CSR_K_OFFSET: k_off_r  = val[0];
         plnk_pkg::CSR_PD_EN:    pd_en_r  = val[0];
         plnk_pkg::CSR_PD_VALUE: pd_val_r = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every command is taken and answered, then a short pause
   task automatic drain(input int extra);
      while (n_accepted != n_queued || answers.size() != 0)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // random register setting, mostly narrow ranges so searches stay short;
   // upper data bits are random to exercise the width masking
   task automatic shuffle_regs();
      logic [5:0] lo, hi;
      logic [2:0] klo, khi;
      lo  = ($urandom_range(99) < 15) ? 6'($urandom) : 6'($urandom_range(6));
      hi  = ($urandom_range(99) < 25) ? 6'd0 : 6'($urandom_range(63, lo));
      klo = ($urandom_range(99) < 15) ? 3'($urandom) : 3'($urandom_range(2));
      khi = ($urandom_range(99) < 25) ? 3'd0 : 3'($urandom_range(7, klo));
      write_reg(plnk_pkg::CSR_N_MIN, lo);
      write_reg(plnk_pkg::CSR_N_MAX, hi);
      write_reg(plnk_pkg::CSR_K_MIN, {3'($urandom), klo});
      write_reg(plnk_pkg::CSR_K_MAX, {3'($urandom), khi});
      write_reg(plnk_pkg::CSR_N_OFFSET, 6'($urandom));
      write_reg(plnk_pkg::CSR_K_OFFSET, 6'($urandom));
      write_reg(plnk_pkg::CSR_PD_EN, 6'($urandom));
      write_reg(plnk_pkg::CSR_PD_VALUE, 6'($urandom));
      n_settings++;
   endtask

   // mostly a target that is some multiple of the parent plus a little,
   // so the search actually finds pairs; the rest is raw noise
   task automatic random_cmd();
      logic [plnk_pkg::FUNC_W-1:0] fn;
      logic [plnk_pkg::RATE_W-1:0] parent, target;
      longint unsigned t;
      int unsigned roll;
      roll = $urandom_range(99);
      fn = (roll < 35) ? plnk_pkg::FUNC_ROUND : (roll < 65) ? plnk_pkg::FUNC_SET :
           (roll < 93) ? plnk_pkg::FUNC_RECALC : FUNC_UNUSED;
      case ($urandom_range(3))
         0: parent = $urandom;
         1: parent = $urandom >> $urandom_range(8, 31);
         2: parent = $urandom_range(1000);
         default: parent = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      endcase
      if ($urandom_range(99) < 75) begin
         t = 64'(parent) * $urandom_range(300);
         if ($urandom_range(3) != 0)
            t = t + $urandom_range(parent);
         target = (t > 64'hFFFF_FFFF) ? $urandom : t[31:0];
      end else begin
         target = $urandom;
      end
      send(fn, parent, target);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset setting: N 1..32, K 1..4, offsets 1, no post divider
      send(plnk_pkg::FUNC_RECALC, 32'd1_000_000, 32'd0);        // codes zero give 1 x 1
      send(plnk_pkg::FUNC_RECALC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(plnk_pkg::FUNC_ROUND, 32'd0, 32'd1000);               // zero products never chosen
      send(plnk_pkg::FUNC_ROUND, 32'd1000, 32'd0);               // nothing fits
      send(plnk_pkg::FUNC_ROUND, 32'd1_000_000, 32'd12_000_000); // tie: first pair wins
      send(plnk_pkg::FUNC_ROUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(plnk_pkg::FUNC_SET, 32'd24_000_000, 32'd600_000_000);
      send(plnk_pkg::FUNC_RECALC, 32'd24_000_000, 32'd0);
      send(plnk_pkg::FUNC_RECALC, 32'hFFFF_FFFF, 32'd0);         // saturates
      send(plnk_pkg::FUNC_SET, 32'd100, 32'd99);                 // no fit, codes wrap below zero
      send(plnk_pkg::FUNC_RECALC, 32'd3, 32'd0);
      send(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(plnk_pkg::FUNC_ROUND, 32'd1, 32'hFFFF_FFFF);
      drain(8);

      // zero offsets, post divider enabled with a value of zero
      write_reg(plnk_pkg::CSR_N_OFFSET, 6'd0);
      write_reg(plnk_pkg::CSR_K_OFFSET, 6'd0);
      write_reg(plnk_pkg::CSR_PD_EN, 6'd1);
      write_reg(plnk_pkg::CSR_PD_VALUE, 6'd0);
      n_settings++;
      send(plnk_pkg::FUNC_SET, 32'd100, 32'd50);                 // stores zero codes
      send(plnk_pkg::FUNC_RECALC, 32'd7, 32'd0);                 // zero factors count as one
      send(plnk_pkg::FUNC_ROUND, 32'd10, 32'd1000);
      drain(8);

      // empty N range; divider of 16 written with a high bit set
      write_reg(plnk_pkg::CSR_PD_VALUE, 6'h30);
      write_reg(plnk_pkg::CSR_N_MIN, 6'd10);
      write_reg(plnk_pkg::CSR_N_MAX, 6'd5);
      n_settings++;
      send(plnk_pkg::FUNC_ROUND, 32'd1, 32'd1000);
      send(plnk_pkg::FUNC_SET, 32'd1, 32'd1000);
      drain(8);

      // widest ranges, zero factors allowed
      write_reg(plnk_pkg::CSR_N_MIN, 6'd0);
      write_reg(plnk_pkg::CSR_N_MAX, 6'd63);
      write_reg(plnk_pkg::CSR_K_MIN, 6'd0);
      write_reg(plnk_pkg::CSR_K_MAX, 6'd7);
      write_reg(plnk_pkg::CSR_N_OFFSET, 6'd1);
      write_reg(plnk_pkg::CSR_K_OFFSET, 6'd1);
      n_settings++;
      send(plnk_pkg::FUNC_ROUND, 32'd1000, 32'hFFFF_FFFF);
      send(plnk_pkg::FUNC_ROUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(plnk_pkg::FUNC_SET, 32'd5, 32'd3);
      send(plnk_pkg::FUNC_RECALC, 32'hFFFF_FFFF, 32'd0);
      drain(8);

      // random part: ten settings of fifty commands, one phase without gaps
      for (int ph = 0; ph < 10; ph++) begin
         shuffle_regs();
         gaps_on = (ph != 3);
         for (int i = 0; i < 50; i++)
            random_cmd();
         drain(8);
      end

      drain(TAIL_WAIT);
      $display("Checked %0d result beats from %0d commands across %0d register settings",
               n_checked, n_accepted, n_settings);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
